[src/ocmw_pkg.sv]
// ----------------------------------------------------------------------------
// ocmw_pkg
// Shared types, sizes and helpers for the outlet current monitor / watchdog.
// ----------------------------------------------------------------------------
package ocmw_pkg;

    localparam int NUM_CHANNELS  = 8;
    localparam int WINDOW_LEN    = 10;
    localparam int SAMPLE_BITS   = 10;

    localparam int SAMPLE_IN_W   = 10;
    localparam int AVG_OUT_W     = 10;
    localparam int IN_TDATA_W    = 16;
    localparam int OUT_TDATA_W   = 32;

    localparam int CH_W          = (NUM_CHANNELS > 1) ? $clog2(NUM_CHANNELS) : 1;
    localparam int SLOT_W        = (WINDOW_LEN > 1) ? $clog2(WINDOW_LEN) : 1;
    localparam int STORE_DEPTH   = NUM_CHANNELS * WINDOW_LEN;
    localparam int ADDR_W        = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
    localparam int SUM_W         = $clog2(WINDOW_LEN * ((1 << SAMPLE_BITS) - 1) + 1);
    localparam int AVG_W         = SAMPLE_BITS;

    // floor(x / WINDOW_LEN) == (x * RECIP) >> DIV_SHIFT for every x below 2**SUM_W
    localparam int DIV_L         = $clog2(WINDOW_LEN);
    localparam int DIV_SHIFT     = SUM_W + DIV_L;
    localparam int RECIP_W       = DIV_SHIFT + 1;
    localparam int RECIP_INT     = ((1 << DIV_SHIFT) + WINDOW_LEN - 1) / WINDOW_LEN;
    localparam int PROD_W        = SUM_W + RECIP_W;

    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    localparam logic [7:0] TIMEOUT_RESET = 8'd200;

    typedef enum logic [2:0] {
        FUNC_CONV_DONE = 3'd0,
        FUNC_TICK      = 3'd1,
        FUNC_SET_FB    = 3'd2,
        FUNC_SET_RELAY = 3'd3,
        FUNC_RD_CUR    = 3'd4,
        FUNC_STATUS    = 3'd5,
        FUNC_RD_ALL    = 3'd6
    } t_func;

    typedef enum logic [2:0] {
        OP_CONV,
        OP_TICK,
        OP_SET_FB,
        OP_SET_RELAY,
        OP_RD_CUR,
        OP_STATUS,
        OP_RD_ALL,
        OP_NOP
    } t_op;

    typedef enum logic [1:0] {
        KIND_EVENT   = 2'd0,
        KIND_ACK     = 2'd1,
        KIND_READING = 2'd2,
        KIND_STATUS  = 2'd3
    } t_kind;

    typedef struct packed {
        t_op                    op;
        logic [SAMPLE_BITS-1:0] sample;
        logic [2:0]             outlet;
        logic                   bit_value;
        logic                   ac_power_present;
    } t_cmd;

    function automatic logic [4:0] chan_code(input logic [2:0] ch);
        logic [4:0] code;
        unique case (ch)
            3'd0:    code = 5'b00000;
            3'd1:    code = 5'b00001;
            3'd2:    code = 5'b00010;
            3'd3:    code = 5'b00011;
            3'd4:    code = 5'b00101;
            3'd5:    code = 5'b00110;
            3'd6:    code = 5'b00111;
            default: code = 5'b01000;
        endcase
        return code;
    endfunction

    function automatic logic [7:0] set_bit(input logic [7:0] v, input logic [2:0] pos,
                                           input logic b);
        logic [7:0] r;
        r      = v;
        r[pos] = b;
        return r;
    endfunction

endpackage

[src/outlet_current_monitor_watchdog.sv]
// ----------------------------------------------------------------------------
// outlet_current_monitor_watchdog
// Eight-outlet current monitor with a host communication watchdog.
// ----------------------------------------------------------------------------
// Commands are taken one at a time by the execution section; a two-entry
// queue behind the input port lets the host keep sending while a result is
// held. A conversion-done beat passes through the idle state (sample memory
// read), the sum state (sum update and write) and the emit state (average and
// result), set by the read-modify-write of the single-port sample store. Ticks
// and other commands go from idle straight to emit, read-all emits one result
// beat per cycle while the output is not stalled, and an unknown func leaves
// the block idle with no result. Downstream stalls hold the emit state. The
// sample store is cleared at reset through per-entry valid bits, so no clearing
// pass is needed. The timeout register may be written any time the block is idle.
module outlet_current_monitor_watchdog (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [7:0]                        i_cfg_data,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    // sample[9:0], outlet[12:10], bit_value[13], ac_power_present[14], zero[15]
    input  logic [ocmw_pkg::IN_TDATA_W-1:0]   i_s_axis_tdata,
    // func[2:0]
    input  logic [2:0]                        i_s_axis_tuser,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // reading_outlet[2:0], current_avg[12:3], relays[20:13], ac_power[21],
    // comm_error[22], start_conversion[23], adc_channel[28:24], zero[31:29]
    output logic [ocmw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);
    import ocmw_pkg::*;

    logic push;
    logic full;
    logic empty;
    logic pop;
    t_cmd front_cmd;
    t_cmd queue_cmd;

    ocmw_front u_front (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_push          (push),
        .o_cmd           (front_cmd),
        .i_full          (full)
    );

    ocmw_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (front_cmd),
        .o_full  (full),
        .i_pop   (pop),
        .o_cmd   (queue_cmd),
        .o_empty (empty)
    );

    ocmw_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_data      (i_cfg_data),
        .i_cmd           (queue_cmd),
        .i_empty         (empty),
        .o_pop           (pop),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .o_m_axis_tlast  (o_m_axis_tlast)
    );

endmodule

[src/ocmw_front.sv]
// ----------------------------------------------------------------------------
// ocmw_front
// Input side: takes stream beats, decodes func into an operation and packs
// the command for the queue.
// ----------------------------------------------------------------------------
module ocmw_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_s_axis_tvalid,
    output logic                               o_s_axis_tready,
    // sample[9:0], outlet[12:10], bit_value[13], ac_power_present[14], zero[15]
    input  logic [ocmw_pkg::IN_TDATA_W-1:0]    i_s_axis_tdata,
    // func[2:0]
    input  logic [2:0]                         i_s_axis_tuser,
    output logic                               o_push,
    output ocmw_pkg::t_cmd                     o_cmd,
    input  logic                               i_full
);
    import ocmw_pkg::*;

    logic [SAMPLE_IN_W-1:0] sample_in;
    t_op                    op;

    assign sample_in       = i_s_axis_tdata[SAMPLE_IN_W-1:0];
    assign o_s_axis_tready = !i_full;
    assign o_push          = i_s_axis_tvalid && !i_full;

    always_comb begin
        unique case (t_func'(i_s_axis_tuser))
            FUNC_CONV_DONE: op = OP_CONV;
            FUNC_TICK:      op = OP_TICK;
            FUNC_SET_FB:    op = OP_SET_FB;
            FUNC_SET_RELAY: op = OP_SET_RELAY;
            FUNC_RD_CUR:    op = OP_RD_CUR;
            FUNC_STATUS:    op = OP_STATUS;
            FUNC_RD_ALL:    op = OP_RD_ALL;
            default:        op = OP_NOP;
        endcase
    end

    always_comb begin
        o_cmd.op               = op;
        o_cmd.sample           = SAMPLE_BITS'(sample_in);
        o_cmd.outlet           = i_s_axis_tdata[SAMPLE_IN_W+2:SAMPLE_IN_W];
        o_cmd.bit_value        = i_s_axis_tdata[SAMPLE_IN_W+3];
        o_cmd.ac_power_present = i_s_axis_tdata[SAMPLE_IN_W+4];
    end

    a_no_push_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full)
        else $error("push into full queue");

endmodule

[src/ocmw_queue.sv]
// ----------------------------------------------------------------------------
// ocmw_queue
// Short command queue between the front and back sections.
// ----------------------------------------------------------------------------
module ocmw_queue (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_push,
    input  ocmw_pkg::t_cmd i_cmd,
    output logic           o_full,
    input  logic           i_pop,
    output ocmw_pkg::t_cmd o_cmd,
    output logic           o_empty
);
    import ocmw_pkg::*;

    t_cmd              r_q [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wp;
    logic [QPTR_W-1:0] r_rp;
    logic [QCNT_W-1:0] r_cnt;
    logic              do_push;
    logic              do_pop;

    assign o_full  = (r_cnt == QCNT_W'(QUEUE_DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_cmd   = r_q[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wp <= (r_wp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_wp + 1'b1;
            end
            if (do_pop) begin
                r_rp <= (r_rp == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : r_rp + 1'b1;
            end
            unique case ({do_push, do_pop})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_q[r_wp] <= i_cmd;
        end
    end

endmodule

[src/ocmw_back.sv]
// ----------------------------------------------------------------------------
// ocmw_back
// Execution side: sample store, running sums and averages, channel sequencing,
// silence watchdog, relay and fallback masks, and the result register.
// ----------------------------------------------------------------------------
module ocmw_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    output logic                              o_cfg_ready,
    input  logic [7:0]                        i_cfg_data,
    input  ocmw_pkg::t_cmd                    i_cmd,
    input  logic                              i_empty,
    output logic                              o_pop,
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    // reading_outlet[2:0], current_avg[12:3], relays[20:13], ac_power[21],
    // comm_error[22], start_conversion[23], adc_channel[28:24], zero[31:29]
    output logic [ocmw_pkg::OUT_TDATA_W-1:0]  o_m_axis_tdata,
    // kind[1:0]
    output logic [1:0]                        o_m_axis_tuser,
    output logic                              o_m_axis_tlast
);
    import ocmw_pkg::*;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SUM,
        S_EMIT
    } t_state;

    localparam logic [RECIP_W-1:0] RECIP = RECIP_W'(RECIP_INT);

    t_state                 r_state;
    t_cmd                   r_cmd;
    logic [CH_W-1:0]        r_ch;
    logic [SLOT_W-1:0]      r_slot;
    logic [CH_W-1:0]        r_last_started;
    logic [CH_W-1:0]        r_k;
    logic [7:0]             r_cnt;
    logic                   r_flag;
    logic [7:0]             r_fb;
    logic [7:0]             r_relay;
    logic [7:0]             r_timeout;
    logic [SUM_W-1:0]       r_sum [NUM_CHANNELS];
    logic [AVG_W-1:0]       r_avg [NUM_CHANNELS];
    logic [SUM_W-1:0]       r_sum_new;

    logic [SAMPLE_BITS-1:0] r_mem [STORE_DEPTH];
    logic [STORE_DEPTH-1:0] r_vld;
    logic [SAMPLE_BITS-1:0] r_mem_q;
    logic                   r_old_vld;

    logic                   r_m_tvalid;
    logic [OUT_TDATA_W-1:0] r_m_tdata;
    logic [1:0]             r_m_tuser;
    logic                   r_m_tlast;

    logic                   out_free;
    logic                   emit_go;
    logic                   pop;
    logic [ADDR_W-1:0]      mem_addr;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SUM_W-1:0]       n_sum;
    logic [PROD_W-1:0]      prod;
    logic [AVG_W-1:0]       avg_new;
    logic [CH_W-1:0]        avg_idx;
    logic                   outlet_ok;
    logic                   all_last;

    logic [CH_W-1:0]        n_ch;
    logic [SLOT_W-1:0]      n_slot;
    logic [CH_W-1:0]        n_last_started;
    logic [7:0]             n_cnt;
    logic [7:0]             cnt_inc;
    logic                   n_flag;
    logic [7:0]             n_fb;
    logic [7:0]             n_relay;
    t_kind                  res_kind;
    logic [2:0]             res_outlet;
    logic [AVG_W-1:0]       res_avg;
    logic                   res_ac;
    logic                   res_start;
    logic                   res_last;
    logic                   n_done;

    assign o_cfg_ready     = 1'b1;
    assign out_free        = !r_m_tvalid || i_m_axis_tready;
    assign emit_go         = (r_state == S_EMIT) && out_free;
    assign pop             = (r_state == S_IDLE) && !i_empty;
    assign o_pop           = pop;
    assign mem_addr        = ADDR_W'(int'(r_ch) * WINDOW_LEN + int'(r_slot));
    assign old_sample      = r_old_vld ? r_mem_q : '0;
    assign n_sum           = r_sum[r_ch] - SUM_W'(old_sample) + SUM_W'(r_cmd.sample);
    assign prod            = PROD_W'(r_sum_new) * PROD_W'(RECIP);
    assign avg_new         = AVG_W'(prod >> DIV_SHIFT);
    assign all_last        = (r_k == CH_W'(NUM_CHANNELS - 1));
    assign outlet_ok       = ({1'b0, r_cmd.outlet} < 4'(NUM_CHANNELS));
    assign avg_idx         = (r_cmd.op == OP_RD_ALL) ? r_k : CH_W'(r_cmd.outlet);
    assign cnt_inc         = r_cnt + 8'd1;

    assign o_m_axis_tvalid = r_m_tvalid;
    assign o_m_axis_tdata  = r_m_tdata;
    assign o_m_axis_tuser  = r_m_tuser;
    assign o_m_axis_tlast  = r_m_tlast;

    // effects and result of the command being emitted
    always_comb begin
        n_ch           = r_ch;
        n_slot         = r_slot;
        n_last_started = r_last_started;
        n_cnt          = 8'd0;
        n_flag         = r_flag;
        n_fb           = r_fb;
        n_relay        = r_relay;
        res_kind       = KIND_EVENT;
        res_outlet     = 3'd0;
        res_avg        = '0;
        res_ac         = 1'b0;
        res_start      = 1'b0;
        res_last       = 1'b1;
        n_done         = 1'b1;
        unique case (r_cmd.op)
            OP_CONV: begin
                n_cnt      = r_cnt;
                res_outlet = 3'(r_ch);
                res_avg    = avg_new;
                if (r_ch == CH_W'(NUM_CHANNELS - 1)) begin
                    n_ch   = '0;
                    n_slot = (r_slot == SLOT_W'(WINDOW_LEN - 1)) ? '0 : r_slot + 1'b1;
                end else begin
                    n_ch   = r_ch + 1'b1;
                end
            end
            OP_TICK: begin
                n_cnt = r_cnt;
                if (r_ch != r_last_started) begin
                    res_start      = 1'b1;
                    n_last_started = r_ch;
                end
                if (!r_flag) begin
                    n_cnt = cnt_inc;
                    if (cnt_inc >= r_timeout) begin
                        n_relay = r_fb;
                        n_flag  = 1'b1;
                    end
                end else if (r_cnt == 8'd0) begin
                    n_flag = 1'b0;
                end
            end
            OP_SET_FB: begin
                n_fb     = set_bit(r_fb, r_cmd.outlet, r_cmd.bit_value);
                res_kind = KIND_ACK;
            end
            OP_SET_RELAY: begin
                n_relay  = set_bit(r_relay, r_cmd.outlet, r_cmd.bit_value);
                res_kind = KIND_ACK;
            end
            OP_RD_CUR: begin
                res_kind   = KIND_READING;
                res_outlet = r_cmd.outlet;
                res_avg    = outlet_ok ? r_avg[avg_idx] : '0;
            end
            OP_STATUS: begin
                res_kind = KIND_STATUS;
                res_ac   = r_cmd.ac_power_present;
            end
            OP_RD_ALL: begin
                res_kind   = KIND_READING;
                res_outlet = 3'(r_k);
                res_avg    = r_avg[avg_idx];
                res_last   = all_last;
                n_done     = all_last;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state        <= S_IDLE;
            r_ch           <= '0;
            r_slot         <= '0;
            r_last_started <= CH_W'(NUM_CHANNELS - 1);
            r_k            <= '0;
            r_cnt          <= 8'd0;
            r_flag         <= 1'b0;
            r_fb           <= 8'd0;
            r_relay        <= 8'd0;
            r_timeout      <= TIMEOUT_RESET;
            r_vld          <= '0;
            r_m_tvalid     <= 1'b0;
            for (int i = 0; i < NUM_CHANNELS; i++) begin
                r_sum[i] <= '0;
                r_avg[i] <= '0;
            end
        end else begin
            if (i_cfg_valid) begin
                r_timeout <= i_cfg_data;
            end
            if (emit_go) begin
                r_m_tvalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_m_tvalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (pop) begin
                        r_k <= '0;
                        unique case (i_cmd.op)
                            OP_CONV: r_state <= S_SUM;
                            OP_NOP:  r_cnt   <= 8'd0;
                            default: r_state <= S_EMIT;
                        endcase
                    end
                end
                S_SUM: begin
                    r_sum[r_ch]     <= n_sum;
                    r_vld[mem_addr] <= 1'b1;
                    r_state         <= S_EMIT;
                end
                S_EMIT: begin
                    if (emit_go) begin
                        r_ch           <= n_ch;
                        r_slot         <= n_slot;
                        r_last_started <= n_last_started;
                        r_cnt          <= n_cnt;
                        r_flag         <= n_flag;
                        r_fb           <= n_fb;
                        r_relay        <= n_relay;
                        if (r_cmd.op == OP_CONV) begin
                            r_avg[r_ch] <= avg_new;
                        end
                        if (n_done) begin
                            r_state <= S_IDLE;
                            r_k     <= '0;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    // payload: command latch, sample memory, result register
    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_cmd <= i_cmd;
        end
        if (r_state == S_IDLE) begin
            r_mem_q   <= r_mem[mem_addr];
            r_old_vld <= r_vld[mem_addr];
        end
        if (r_state == S_SUM) begin
            r_mem[mem_addr] <= r_cmd.sample;
            r_sum_new       <= n_sum;
        end
        if (emit_go) begin
            r_m_tuser <= res_kind;
            r_m_tlast <= res_last;
            r_m_tdata <= OUT_TDATA_W'({chan_code(3'(n_ch)), res_start, n_flag, res_ac,
                                       n_relay, AVG_OUT_W'(res_avg), res_outlet});
        end
    end

    a_pop_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> (r_state == S_IDLE))
        else $error("queue popped while busy");

    a_err_from_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_flag) |-> $past(emit_go && (r_cmd.op == OP_TICK)))
        else $error("comm error raised outside a tick");

    a_k_only_rdall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_k != '0) |-> ((r_state == S_EMIT) && (r_cmd.op == OP_RD_ALL)))
        else $error("read-all index active outside read-all");

    a_sum_then_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SUM) |=> (r_state == S_EMIT))
        else $error("sum update not followed by emit");

    a_ch_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        int'(r_ch) < NUM_CHANNELS)
        else $error("channel pointer out of range");

endmodule
